FILE: sv/ttbf_pkg.sv
// ttbf_pkg: shared types and constants for the tagged token bucket filter
// used by the interfaces, the shared arithmetic unit and the top level
`default_nettype none
package ttbf_pkg;

  // default table depth and fraction bits
  localparam int ENTRIES_DEF   = 16;
  localparam int FRAC_BITS_DEF = 16;

  // fixed field widths
  localparam int CMD_W   = 3;
  localparam int TAG_W   = 32;
  localparam int TIME_W  = 64;
  localparam int SIZE_W  = 32;
  localparam int RATE_W  = 48;
  localparam int BURST_W = 32;
  localparam int CNT_W   = 32;

  // command codes
  localparam logic [CMD_W-1:0] CMD_CHECK = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REG   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_EDIT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEREG = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

  // shared unit modes
  localparam logic ALU_MUL = 1'b0;
  localparam logic ALU_DIV = 1'b1;

  // product saturation point
  localparam logic [TIME_W-1:0] PROD_SAT = 64'h4000_0000_0000_0000;

  typedef struct packed {
    logic start;
    logic mode;
  } alu_req_t;

endpackage
`default_nettype wire

FILE: sv/ttbf_if.sv
// ttbf_if: handshake channel interfaces for input, result and config beats
// depends on ttbf_pkg for field widths
`default_nettype none
interface ttbf_in_if;
  logic                             valid;
  logic                             ready;
  logic [ttbf_pkg::CMD_W-1:0]       cmd;
  logic [ttbf_pkg::TAG_W-1:0]       tag;
  logic signed [ttbf_pkg::TIME_W-1:0] now_time;
  logic [ttbf_pkg::SIZE_W-1:0]      data_size;
  logic [ttbf_pkg::RATE_W-1:0]      new_rate;
  logic [ttbf_pkg::BURST_W-1:0]     new_burst;
  modport source (output valid, cmd, tag, now_time, data_size, new_rate, new_burst,
                  input ready);
  modport sink (input valid, cmd, tag, now_time, data_size, new_rate, new_burst,
                output ready);
endinterface

interface ttbf_out_if;
  logic                       valid;
  logic                       ready;
  logic                       dropped;
  logic                       tag_found;
  logic                       cmd_ok;
  logic [ttbf_pkg::CNT_W-1:0] passed_count;
  logic [ttbf_pkg::CNT_W-1:0] dropped_count;
  modport source (output valid, dropped, tag_found, cmd_ok, passed_count, dropped_count,
                  input ready);
  modport sink (input valid, dropped, tag_found, cmd_ok, passed_count, dropped_count,
                output ready);
endinterface

interface ttbf_cfg_if;
  logic valid;
  logic ready;
  logic count_filtered;
  modport source (output valid, count_filtered, input ready);
  modport sink (input valid, count_filtered, output ready);
endinterface
`default_nettype wire

FILE: sv/ttbf_alu.sv
// ttbf_alu: shared bit-serial unit, saturating multiply or restoring divide
// depends on ttbf_pkg for the request struct, modes and saturation point
`default_nettype none
module ttbf_alu #(
  parameter int FRAC_BITS = ttbf_pkg::FRAC_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire ttbf_pkg::alu_req_t          req,
  input  wire [ttbf_pkg::RATE_W-1:0]       op_rate,
  input  wire [ttbf_pkg::TIME_W-1:0]       op_mag,
  output logic                             done,
  output logic [ttbf_pkg::TIME_W-1:0]      result
);

  localparam logic [6:0] MUL_LAST = 7'd63;
  localparam logic [6:0] DIV_LAST = 7'(FRAC_BITS);

  logic                          busy_r;
  logic                          done_r;
  logic                          mode_r;
  logic [6:0]                    cnt_r;
  logic [ttbf_pkg::TIME_W-1:0]   acc_r, acc_nxt;
  logic [ttbf_pkg::TIME_W-1:0]   sh_r, sh_nxt;
  logic [ttbf_pkg::RATE_W-1:0]   rate_r;
  logic [ttbf_pkg::TIME_W-1:0]   mul_sum;
  logic [ttbf_pkg::RATE_W:0]     rem2;
  logic                          ge;
  logic                          last;

  // one step of either operation
  always_comb begin
    mul_sum = {acc_r[62:0], 1'b0} + (sh_r[63] ? {16'd0, rate_r} : 64'd0);
    rem2    = {acc_r[ttbf_pkg::RATE_W-1:0], (cnt_r == 7'd0)};
    ge      = rem2 >= {1'b0, rate_r};
    if (mode_r == ttbf_pkg::ALU_MUL) begin
      acc_nxt = (mul_sum > ttbf_pkg::PROD_SAT) ? ttbf_pkg::PROD_SAT : mul_sum;
      sh_nxt  = {sh_r[62:0], 1'b0};
      last    = (cnt_r == MUL_LAST);
    end else begin
      acc_nxt = ge ? 64'(rem2 - {1'b0, rate_r}) : 64'(rem2);
      sh_nxt  = {sh_r[62:0], ge};
      last    = (cnt_r == DIV_LAST);
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 7'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 7'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 7'd1;
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      mode_r <= req.mode;
      rate_r <= op_rate;
      acc_r  <= '0;
      sh_r   <= (req.mode == ttbf_pkg::ALU_MUL) ? op_mag : '0;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      sh_r  <= sh_nxt;
    end
  end

  assign done   = done_r;
  assign result = (mode_r == ttbf_pkg::ALU_MUL) ? acc_r : sh_r;

endmodule
`default_nettype wire

FILE: sv/tagged_token_bucket_filter.sv
// tagged_token_bucket_filter: token bucket table keyed by tag, with sequencer
// depends on ttbf_pkg, the channel interfaces and ttbf_alu
//
// usage
//   in_ch carries one command beat (check, register, edit, deregister, clear all)
//   out_ch returns exactly one result beat per command, with the running counters
//   cfg_ch writes count_filtered; it is always ready and meant for idle periods
// timing
//   one command at a time: in_ch.ready is high only while the block is idle
//   every command first scans the whole table, one entry a cycle
//   a check on a known tag then runs a 64-step saturating multiply on the shared
//   shift-add unit, then add, subtract and clamp steps; if dt overflows, only
//   the clamp step runs; register and edit run FRAC_BITS+1 divide steps on
//   the same unit when they succeed
// reset
//   all entries invalid, both counters zero, count_filtered set
// stalls
//   the result is held in an output register until out_ch.ready; no new
//   command is taken until then
`default_nettype none
module tagged_token_bucket_filter #(
  parameter int ENTRIES   = ttbf_pkg::ENTRIES_DEF,
  parameter int FRAC_BITS = ttbf_pkg::FRAC_BITS_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  ttbf_in_if.sink    in_ch,
  ttbf_out_if.source out_ch,
  ttbf_cfg_if.sink   cfg_ch
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int LW = ttbf_pkg::BURST_W + FRAC_BITS;
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_SUM   = 4'd4;
  localparam logic [3:0] S_SUB   = 4'd5;
  localparam logic [3:0] S_WRITE = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_RES   = 4'd8;
  localparam logic [3:0] S_DT    = 4'd9;

  logic [3:0] state_r, state_nxt;

  // latched command
  logic [ttbf_pkg::CMD_W-1:0]   cmd_r;
  logic [ttbf_pkg::TAG_W-1:0]   tag_r;
  logic [ttbf_pkg::TIME_W-1:0]  now_r;
  logic [ttbf_pkg::SIZE_W-1:0]  size_r;
  logic [ttbf_pkg::RATE_W-1:0]  nrate_r;
  logic [ttbf_pkg::BURST_W-1:0] nburst_r;

  // table
  logic [ENTRIES-1:0]           valid_r;
  logic [ttbf_pkg::TAG_W-1:0]   tag_arr_r   [ENTRIES];
  logic [ttbf_pkg::RATE_W-1:0]  rate_arr_r  [ENTRIES];
  logic [ttbf_pkg::BURST_W-1:0] burst_arr_r [ENTRIES];
  logic [ttbf_pkg::TIME_W-1:0]  last_arr_r  [ENTRIES];
  logic [LW-1:0]                level_arr_r [ENTRIES];

  // scan results
  logic [IW-1:0] scan_idx_r;
  logic          found_r;
  logic [IW-1:0] hit_idx_r;
  logic          free_ok_r;
  logic [IW-1:0] free_idx_r;

  // check datapath
  logic [ttbf_pkg::TIME_W-1:0] dt_r;
  logic                        ovf_r;
  logic [ttbf_pkg::TIME_W-1:0] pos_r, neg_r;
  logic [ttbf_pkg::TIME_W:0]   diff_r;

  // counters, config, result
  logic [ttbf_pkg::CNT_W-1:0] pass_cnt_r, drop_cnt_r;
  logic                       count_filt_r;
  logic                       res_drop_r, res_ok_r;

  // shared unit
  ttbf_pkg::alu_req_t          alu_req;
  logic                        alu_done;
  logic [ttbf_pkg::TIME_W-1:0] alu_res;
  logic [ttbf_pkg::TIME_W-1:0] alu_mag;

  // entry at hit index
  logic [ttbf_pkg::TIME_W-1:0] e_last;
  logic [ttbf_pkg::RATE_W-1:0] e_rate;
  logic [LW-1:0]               e_level;
  logic [LW-1:0]               e_cap;
  logic [ttbf_pkg::TIME_W-1:0] dt_now;
  logic                        in_beat;
  logic                        cmd_go;

  assign e_last  = last_arr_r[hit_idx_r];
  assign e_rate  = rate_arr_r[hit_idx_r];
  assign e_level = level_arr_r[hit_idx_r];
  assign e_cap   = {burst_arr_r[hit_idx_r], {FRAC_BITS{1'b0}}};
  assign dt_now  = now_r - e_last;
  assign in_beat = in_ch.valid && in_ch.ready;
  assign alu_mag = dt_r[63] ? (64'd0 - dt_r) : dt_r;

  // register and edit need a non-zero rate
  assign cmd_go = (nrate_r != '0) &&
                  (((cmd_r == ttbf_pkg::CMD_REG) && !found_r && free_ok_r) ||
                   ((cmd_r == ttbf_pkg::CMD_EDIT) && found_r));

  ttbf_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (alu_req),
    .op_rate ((state_r == S_DT) ? e_rate : nrate_r),
    .op_mag  (alu_mag),
    .done    (alu_done),
    .result  (alu_res)
  );

  // unit start
  always_comb begin
    alu_req.start = 1'b0;
    alu_req.mode  = ttbf_pkg::ALU_MUL;
    if (state_r == S_DT && !ovf_r) begin
      alu_req.start = 1'b1;
    end else if (state_r == S_DISP && cmd_go) begin
      alu_req.start = 1'b1;
      alu_req.mode  = ttbf_pkg::ALU_DIV;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_beat) state_nxt = S_SCAN;
      S_SCAN:  if (scan_idx_r == LAST_IDX) state_nxt = S_DISP;
      S_DISP: begin
        if (cmd_r == ttbf_pkg::CMD_CHECK && found_r) state_nxt = S_DT;
        else if (cmd_go)                             state_nxt = S_DIV;
        else                                         state_nxt = S_RES;
      end
      S_DT:    state_nxt = ovf_r ? S_WRITE : S_MUL;
      S_MUL:   if (alu_done) state_nxt = S_SUM;
      S_SUM:   state_nxt = S_SUB;
      S_SUB:   state_nxt = S_WRITE;
      S_WRITE: state_nxt = S_RES;
      S_DIV:   if (alu_done) state_nxt = S_RES;
      S_RES:   if (out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      pass_cnt_r   <= '0;
      drop_cnt_r   <= '0;
      count_filt_r <= 1'b1;
      found_r      <= 1'b0;
      free_ok_r    <= 1'b0;
      scan_idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) count_filt_r <= cfg_ch.count_filtered;
      if (in_beat) begin
        scan_idx_r <= '0;
        found_r    <= 1'b0;
        free_ok_r  <= 1'b0;
      end
      // table scan, one entry a cycle
      if (state_r == S_SCAN) begin
        scan_idx_r <= scan_idx_r + IW'(1);
        if (valid_r[scan_idx_r] && tag_arr_r[scan_idx_r] == tag_r && !found_r) begin
          found_r <= 1'b1;
        end
        if (!valid_r[scan_idx_r] && !free_ok_r) free_ok_r <= 1'b1;
      end
      if (state_r == S_DISP) begin
        if (cmd_r == ttbf_pkg::CMD_DEREG && found_r) valid_r[hit_idx_r] <= 1'b0;
        if (cmd_r == ttbf_pkg::CMD_CLEAR)            valid_r <= '0;
      end
      if (state_r == S_DIV && alu_done && cmd_r == ttbf_pkg::CMD_REG) begin
        valid_r[free_idx_r] <= 1'b1;
      end
      if (state_r == S_WRITE) begin
        if (!ovf_r && diff_r[ttbf_pkg::TIME_W]) begin
          if (count_filt_r) drop_cnt_r <= drop_cnt_r + 32'd1;
        end else begin
          pass_cnt_r <= pass_cnt_r + 32'd1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_beat) begin
      cmd_r      <= in_ch.cmd;
      tag_r      <= in_ch.tag;
      now_r      <= in_ch.now_time;
      size_r     <= in_ch.data_size;
      nrate_r    <= in_ch.new_rate;
      nburst_r   <= in_ch.new_burst;
      res_drop_r <= 1'b0;
    end
    if (state_r == S_SCAN) begin
      if (valid_r[scan_idx_r] && tag_arr_r[scan_idx_r] == tag_r && !found_r) begin
        hit_idx_r <= scan_idx_r;
      end
      if (!valid_r[scan_idx_r] && !free_ok_r) free_idx_r <= scan_idx_r;
    end
    if (state_r == S_DISP) begin
      dt_r     <= dt_now;
      ovf_r    <= (now_r[63] ^ e_last[63]) && (dt_now[63] ^ now_r[63]);
      unique case (cmd_r)
        ttbf_pkg::CMD_CHECK, ttbf_pkg::CMD_CLEAR: res_ok_r <= 1'b1;
        ttbf_pkg::CMD_DEREG:                      res_ok_r <= found_r;
        ttbf_pkg::CMD_REG, ttbf_pkg::CMD_EDIT:    res_ok_r <= cmd_go;
        default:                                  res_ok_r <= 1'b0;
      endcase
    end
    // level plus credit against size plus debit
    if (state_r == S_SUM) begin
      pos_r <= 64'(e_level) + (dt_r[63] ? 64'd0 : alu_res);
      neg_r <= 64'({size_r, {FRAC_BITS{1'b0}}}) + (dt_r[63] ? alu_res : 64'd0);
    end
    if (state_r == S_SUB) diff_r <= {1'b0, pos_r} - {1'b0, neg_r};
    if (state_r == S_WRITE) res_drop_r <= !ovf_r && diff_r[ttbf_pkg::TIME_W];
  end

  // table writes
  always_ff @(posedge clk) begin
    if (state_r == S_WRITE) begin
      if (ovf_r) begin
        last_arr_r[hit_idx_r]  <= now_r;
        level_arr_r[hit_idx_r] <= now_r[63] ? '0 : e_cap;
      end else if (diff_r[ttbf_pkg::TIME_W]) begin
        level_arr_r[hit_idx_r] <= '0;
      end else begin
        last_arr_r[hit_idx_r]  <= now_r;
        level_arr_r[hit_idx_r] <= (diff_r > 65'(e_cap)) ? e_cap : LW'(diff_r);
      end
    end
    if (state_r == S_DIV && alu_done) begin
      if (cmd_r == ttbf_pkg::CMD_REG) begin
        tag_arr_r[free_idx_r]   <= tag_r;
        rate_arr_r[free_idx_r]  <= nrate_r;
        burst_arr_r[free_idx_r] <= nburst_r;
        last_arr_r[free_idx_r]  <= 64'd0 - alu_res;
        level_arr_r[free_idx_r] <= {nburst_r, {FRAC_BITS{1'b0}}};
      end else begin
        rate_arr_r[hit_idx_r]  <= nrate_r;
        burst_arr_r[hit_idx_r] <= nburst_r;
        last_arr_r[hit_idx_r]  <= 64'd0 - alu_res;
      end
    end
  end

  // ports
  assign in_ch.ready          = (state_r == S_IDLE);
  assign cfg_ch.ready         = 1'b1;
  assign out_ch.valid         = (state_r == S_RES);
  assign out_ch.dropped       = res_drop_r;
  assign out_ch.tag_found     = found_r;
  assign out_ch.cmd_ok        = res_ok_r;
  assign out_ch.passed_count  = pass_cnt_r;
  assign out_ch.dropped_count = drop_cnt_r;

  // checks
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_ch.valid && in_ch.ready))
    else $error("result pending while accepting a command");

  a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DISP && found_r) |-> valid_r[hit_idx_r])
    else $error("hit entry not valid");

  a_drop_check: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.dropped) |-> (cmd_r == ttbf_pkg::CMD_CHECK && found_r))
    else $error("drop reported for a non-check command");

  a_unit_done: assert property (@(posedge clk) disable iff (!rst_n)
    alu_done |-> (state_r == S_MUL || state_r == S_DIV))
    else $error("shared unit finished outside a wait state");

endmodule
`default_nettype wire
